/* hw/rtl/dlss_pkg.sv */
// Shared types and constants for the LOOK / FCFS disk seek scheduler.
// No dependencies; imported by disk_look_seek_scheduler_top (dlss_ram does not use it).
package dlss_pkg;

  localparam int TRK_W      = 16;  // track number and seek distance width
  localparam int TOT_W      = 21;  // running seek total width
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;  // track, padded to whole bytes
  localparam int OUT_DATA_W = 56;  // 16 + 16 + 21 = 53, padded to 56

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_START_TRACK = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_MODE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_UP    = 2'd2;

  // Scheduling modes
  localparam logic MODE_FCFS = 1'b0;
  localparam logic MODE_LOOK = 1'b1;

  typedef enum logic [1:0] {
    S_LOAD,  // collect requests
    S_SCAN,  // sweep the store through the key comparator
    S_PICK,  // commit the winner or switch sweep phase
    S_OUT    // hold the result until transfer
  } dlss_state_t;

endpackage

/* hw/rtl/dlss_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module dlss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/disk_look_seek_scheduler_top.sv */
// LOOK / first-come-first-served disk seek scheduler, top level.
// Depends on dlss_pkg and dlss_ram.
//
// Usage:
//   Input stream: one track request per transfer (in_tdata), in_tlast marks the
//   last request of a batch. Requests past MAX_REQUESTS are dropped and the
//   batch is flagged through out_tuser. in_tready is high only while loading,
//   one request per cycle.
//   After the last request the block schedules the batch and sends one result
//   per stored request: served track, seek distance from the previous head
//   position and a saturating running total. out_tlast marks the final result.
//   Each result costs one full pass of the store through a single key
//   comparator: one RAM read per cycle over the n stored requests, the
//   registered RAM read, then a pick state, plus one extra pass when a LOOK
//   sweep reverses. A stalled result is simply held in the output register.
//   The block takes no new request until the last result transfers.
//   The user must write configuration (cfg_we/cfg_addr/cfg_wdata) while idle; the block does not enforce it.
//   Reset (rst_n low, synchronous) empties the batch, sets start track 0,
//   LOOK mode and upward sweep. Store contents are not cleared.
module disk_look_seek_scheduler_top
  import dlss_pkg::*;
#(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] track
  input  logic                  in_tlast,   // last_in_batch
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] served_track,
                                            // [31:16] seek_distance,
                                            // [52:32] total_seek, [55:53] zero
  output logic                  out_tuser,  // [0] overflow
  output logic                  out_tlast   // last_of_run
);

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int KEY_W = TRK_W + IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  dlss_state_t state_r, state_nxt;

  // configuration registers
  logic [TRK_W-1:0] start_r;
  logic             mode_r;
  logic             up_r;

  // batch bookkeeping
  logic [CNT_W-1:0] req_cnt_r;
  logic [CNT_W-1:0] emit_cnt_r;
  logic             drop_r;
  logic [TRK_W-1:0] head_r;
  logic [TOT_W-1:0] total_r;

  // scan sequencer
  logic             phase_r;     // 0 first sweep group, 1 reversed group
  logic             have_prev_r; // a key was already served in this phase
  logic [IDX_W-1:0] scan_idx_r;
  logic             issued_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             found_r;
  logic [TRK_W-1:0] best_trk_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [KEY_W-1:0] prev_key_r;

  // output register
  logic [TRK_W-1:0] out_trk_r;
  logic [TRK_W-1:0] out_dist_r;
  logic [TOT_W-1:0] out_total_r;
  logic             out_ovf_r;
  logic             out_last_r;

  logic             in_acc, out_acc;
  logic             store_full;
  logic             ram_we;
  logic [TRK_W-1:0] ram_rdata;
  logic [IDX_W-1:0] last_idx;
  logic             scan_start;
  logic             scan_done;

  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;
  assign store_full = (req_cnt_r == CNT_MAX);
  assign ram_we     = in_acc & ~store_full;
  assign last_idx   = IDX_W'(req_cnt_r - CNT_W'(1));
  assign scan_done  = cmp_vld_r & (cmp_idx_r == last_idx);

  // Request store in arrival order
  dlss_ram #(
    .WIDTH (TRK_W),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_cnt_r[IDX_W-1:0]),
    .wdata (in_tdata[TRK_W-1:0]),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // Shared key comparator. Key = {track, index} gives a strict order even
  // with duplicate tracks, so no per-entry served bits are needed: in LOOK mode
  // each pass looks for the nearest key beyond the previously served one.
  logic [KEY_W-1:0] cand_key, best_key;
  logic             in_first_grp, grp_ok, asc, after_prev, better, take;

  assign cand_key     = {ram_rdata, cmp_idx_r};
  assign best_key     = {best_trk_r, best_idx_r};
  assign in_first_grp = up_r ? (ram_rdata >= start_r) : (ram_rdata <= start_r);
  assign grp_ok       = phase_r ? ~in_first_grp : in_first_grp;
  assign asc          = up_r ^ phase_r;
  assign after_prev   = ~have_prev_r |
                        (asc ? (cand_key > prev_key_r) : (cand_key < prev_key_r));
  assign better       = ~found_r | (asc ? (cand_key < best_key) : (cand_key > best_key));

  always_comb begin
    if (mode_r == MODE_FCFS) begin
      take = (cmp_idx_r == emit_cnt_r[IDX_W-1:0]);
    end else begin
      take = grp_ok & after_prev & better;
    end
  end

  // Seek distance and saturating total for the picked track
  logic [TRK_W-1:0] seek_dist;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] total_sat;

  assign seek_dist = (best_trk_r >= head_r) ? (best_trk_r - head_r)
                                            : (head_r - best_trk_r);
  assign sum       = {1'b0, total_r} + (TOT_W + 1)'(seek_dist);
  assign total_sat = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

  // Restart a pass on the last request, on a phase switch, or after a result
  assign scan_start = (state_r == S_LOAD && in_acc && in_tlast) ||
                      (state_r == S_PICK && !found_r) ||
                      (state_r == S_OUT && out_acc && !out_last_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (in_acc && in_tlast) state_nxt = S_SCAN;
      S_SCAN: if (scan_done) state_nxt = S_PICK;
      S_PICK: state_nxt = found_r ? S_OUT : S_SCAN;
      S_OUT: begin
        if (out_acc) state_nxt = out_last_r ? S_LOAD : S_SCAN;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = (state_r == S_LOAD);
    out_tvalid = (state_r == S_OUT);
  end

  assign out_tdata = {{(OUT_DATA_W - 2 * TRK_W - TOT_W){1'b0}},
                      out_total_r, out_dist_r, out_trk_r};
  assign out_tuser = out_ovf_r;
  assign out_tlast = out_last_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      start_r     <= '0;
      mode_r      <= MODE_LOOK;
      up_r        <= 1'b1;
      req_cnt_r   <= '0;
      emit_cnt_r  <= '0;
      drop_r      <= 1'b0;
      head_r      <= '0;
      total_r     <= '0;
      phase_r     <= 1'b0;
      have_prev_r <= 1'b0;
      issued_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_START_TRACK: start_r <= cfg_wdata[TRK_W-1:0];
          REG_SCHED_MODE:  mode_r  <= cfg_wdata[0];
          REG_SWEEP_UP:    up_r    <= cfg_wdata[0];
          default: ;
        endcase
      end

      // Load: store while room is left, otherwise drop and flag
      if (in_acc) begin
        if (store_full) begin
          drop_r <= 1'b1;
        end else begin
          req_cnt_r <= req_cnt_r + CNT_W'(1);
        end
        if (in_tlast) begin
          phase_r     <= 1'b0;
          have_prev_r <= 1'b0;
          emit_cnt_r  <= '0;
          total_r     <= '0;
          head_r      <= start_r;
        end
      end

      // Issue one read per cycle until the last stored entry
      cmp_vld_r <= (state_r == S_SCAN) && !issued_r;
      if (scan_start) begin
        issued_r <= 1'b0;
        found_r  <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (!issued_r && scan_idx_r == last_idx) issued_r <= 1'b1;
        if (cmp_vld_r && take) found_r <= 1'b1;
      end

      // Pick: commit the move, or reverse the sweep if the group is exhausted
      if (state_r == S_PICK) begin
        if (found_r) begin
          head_r      <= best_trk_r;
          total_r     <= total_sat;
          have_prev_r <= 1'b1;
        end else begin
          phase_r     <= 1'b1;
          have_prev_r <= 1'b0;
        end
      end

      if (out_acc) begin
        if (out_last_r) begin
          req_cnt_r  <= '0;
          drop_r     <= 1'b0;
          emit_cnt_r <= '0;
        end else begin
          emit_cnt_r <= emit_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (scan_start) begin
      scan_idx_r <= '0;
    end else if (state_r == S_SCAN && !issued_r && scan_idx_r != last_idx) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end

    if (state_r == S_SCAN && cmp_vld_r && take) begin
      best_trk_r <= ram_rdata;
      best_idx_r <= cmp_idx_r;
    end

    if (state_r == S_PICK && found_r) begin
      prev_key_r  <= best_key;
      out_trk_r   <= best_trk_r;
      out_dist_r  <= seek_dist;
      out_total_r <= total_sat;
      out_ovf_r   <= drop_r;
      out_last_r  <= (emit_cnt_r + CNT_W'(1) == req_cnt_r);
    end
  end

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides active together");

  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not back to loading after the final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (req_cnt_r <= CNT_MAX) && (emit_cnt_r < req_cnt_r || state_r == S_LOAD))
    else $error("request or result count out of range");

  a_total_covers_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_total_r >= TOT_W'(out_dist_r)))
    else $error("running total below the current seek distance");

endmodule
